// ===== rtl/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared widths, reset values and register codes of the Laplacian sharpener.
// ----------------------------------------------------------------------------
package lsh_pkg;

	localparam int PIX_W    = 8;   // one channel byte
	localparam int WIDTH_W  = 12;  // width_pixels register
	localparam int HEIGHT_W = 12;  // height_rows register
	localparam int CHAN_W   = 3;   // channel_count register
	localparam int ROW_W    = 11;  // row counter
	localparam int ADDR_W   = 4;   // APB byte address
	localparam int DATA_W   = 32;  // APB data

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd1024;
	localparam logic [CHAN_W-1:0]   CHAN_RST   = 3'd3;

	localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 12'd3;
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = 12'd2048;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 12'd3;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 12'd2048;
	localparam logic [CHAN_W-1:0]   CHAN_MIN   = 3'd1;
	localparam logic [CHAN_W-1:0]   CHAN_MAX   = 3'd4;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2
	} reg_idx_t;

endpackage

// ===== rtl/lsh_pixel_if.sv =====
// ----------------------------------------------------------------------------
// lsh_pixel_if
// Valid/ready channel carrying one input channel byte.
// ----------------------------------------------------------------------------
interface lsh_pixel_if
	import lsh_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_sample;

	modport source (output valid, output pixel_sample, input ready);
	modport sink   (input valid, input pixel_sample, output ready);
endinterface

// ===== rtl/lsh_sharp_if.sv =====
// ----------------------------------------------------------------------------
// lsh_sharp_if
// Valid/ready channel carrying one sharpened byte and the frame end flag.
// ----------------------------------------------------------------------------
interface lsh_sharp_if
	import lsh_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] sharp_sample;
	logic             frame_end;

	modport source (output valid, output sharp_sample, output frame_end, input ready);
	modport sink   (input valid, input sharp_sample, input frame_end, output ready);
endinterface

// ===== rtl/lsh_ram.sv =====
// ----------------------------------------------------------------------------
// lsh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/laplacian_sharpen_3x3.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Streaming 3x3 Laplacian sharpener for interleaved multi-channel 8-bit images.
// ----------------------------------------------------------------------------
// Samples enter one channel byte at a time in raster order, channels
// interleaved. Each result is 5*centre - left - right - up - down of the same
// channel, clamped to 0..255; the first and last rows and pixel columns are
// zero. The result for row r leaves while row r+1 enters, so the first row
// gives nothing and each sample of the last row gives two results (the
// previous row's value, then the zero border of the last row; frame_end marks
// the final one). Throughput: one sample per clock on every row but the last
// while the output is ready; on the last row the single output register sends
// the two results in turn and the input waits. An accepted sample is held in
// stage 1 while the line stores are read, then its result is computed into
// the output register. The line stores are RAMs of MAX_ROW_SAMPLES bytes with
// no clearing pass: their contents are only used once written in the frame.
// Registers (APB, byte address 4*i): 0 width_pixels, 1 height_rows,
// 2 channel_count; values out of range are saturated, and the width is further
// limited to MAX_ROW_SAMPLES / channels. Writing any of them restarts the frame.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3
	import lsh_pkg::*;
#(
	parameter int MAX_ROW_SAMPLES = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	lsh_pixel_if.sink         pixel_in,
	lsh_sharp_if.source       sharp_out
);

	localparam int CW = $clog2(MAX_ROW_SAMPLES);       // column index
	localparam int LW = $clog2(MAX_ROW_SAMPLES + 1);   // row length
	localparam int EW = (LW > WIDTH_W) ? LW : WIDTH_W; // width limiting
	localparam logic [EW-1:0] LIM1 = EW'(MAX_ROW_SAMPLES / 1);
	localparam logic [EW-1:0] LIM2 = EW'(MAX_ROW_SAMPLES / 2);
	localparam logic [EW-1:0] LIM3 = EW'(MAX_ROW_SAMPLES / 3);
	localparam logic [EW-1:0] LIM4 = EW'(MAX_ROW_SAMPLES / 4);

	typedef struct packed {
		logic row_ge1;      // row produces a result
		logic row_ge2;      // result can be interior
		logic interior;     // column away from the left and right border
		logic last_row;     // add the zero border result
		logic last_sample;  // last sample of the row
	} item_flags_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CHAN_W-1:0]   chan_q;
	logic                cfg_wr;
	logic                cfg_restart;
	reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			chan_q   <= CHAN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:    width_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT:   height_q <= pwdata[HEIGHT_W-1:0];
				REG_CHANNELS: chan_q   <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// Restart the frame on any write to a defined register
	always_comb begin
		cfg_restart = 1'b0;
		if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH, REG_HEIGHT, REG_CHANNELS: cfg_restart = 1'b1;
				default: cfg_restart = 1'b0;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:    prdata = DATA_W'(width_q);
			REG_HEIGHT:   prdata = DATA_W'(height_q);
			REG_CHANNELS: prdata = DATA_W'(chan_q);
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Effective geometry: saturate the registers, limit width to the stores
	// ------------------------------------------------------------------
	logic [CHAN_W-1:0]   ch_eff;
	logic [WIDTH_W-1:0]  w_clamp;
	logic [EW-1:0]       w_lim;
	logic [EW-1:0]       w_eff;
	logic [EW+2:0]       len_full;
	logic [LW-1:0]       row_len;
	logic [LW-1:0]       ch_l;
	logic [LW-1:0]       inner_end;
	logic [HEIGHT_W-1:0] h_clamp;
	logic [ROW_W-1:0]    last_row_idx;

	always_comb begin
		if (chan_q < CHAN_MIN) begin
			ch_eff = CHAN_MIN;
		end else if (chan_q > CHAN_MAX) begin
			ch_eff = CHAN_MAX;
		end else begin
			ch_eff = chan_q;
		end

		if (width_q < WIDTH_MIN) begin
			w_clamp = WIDTH_MIN;
		end else if (width_q > WIDTH_MAX) begin
			w_clamp = WIDTH_MAX;
		end else begin
			w_clamp = width_q;
		end

		case (ch_eff)
			3'd1:    w_lim = LIM1;
			3'd2:    w_lim = LIM2;
			3'd3:    w_lim = LIM3;
			default: w_lim = LIM4;
		endcase

		w_eff     = (EW'(w_clamp) > w_lim) ? w_lim : EW'(w_clamp);
		len_full  = (EW+3)'(w_eff) * (EW+3)'(ch_eff);
		row_len   = LW'(len_full);
		ch_l      = LW'(ch_eff);
		inner_end = row_len - ch_l;

		if (height_q < HEIGHT_MIN) begin
			h_clamp = HEIGHT_MIN;
		end else if (height_q > HEIGHT_MAX) begin
			h_clamp = HEIGHT_MAX;
		end else begin
			h_clamp = height_q;
		end
		last_row_idx = ROW_W'(h_clamp - 12'd1);
	end

	// ------------------------------------------------------------------
	// Input side: position counters and item flags
	// ------------------------------------------------------------------
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [LW-1:0]    col_l;
	logic             accept;
	item_flags_t      in_flags;

	assign accept = pixel_in.valid && pixel_in.ready;
	assign col_l  = LW'(col_q);

	always_comb begin
		in_flags.row_ge1     = (row_q != '0);
		in_flags.row_ge2     = (row_q > ROW_W'(1));
		in_flags.interior    = (col_l >= ch_l) && (col_l < inner_end);
		in_flags.last_row    = (row_q == last_row_idx);
		in_flags.last_sample = (col_l == row_len - LW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (in_flags.last_sample) begin
				col_q <= '0;
				row_q <= in_flags.last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: sample held while the line stores are read
	// ------------------------------------------------------------------
	logic             valid_s1;
	logic [PIX_W-1:0] x_s1;
	logic [CW-1:0]    col_s1;
	item_flags_t      flags_s1;
	logic             adv_s1;
	logic             load_ok;

	logic [PIX_W-1:0] up_rd;
	logic [PIX_W-1:0] centre_rd;
	logic [PIX_W-1:0] right_rd;
	logic [CW-1:0]    right_addr;

	// Items of the first row give no result and never wait for the output
	assign adv_s1         = valid_s1 && (!flags_s1.row_ge1 || load_ok);
	assign pixel_in.ready = !valid_s1 || adv_s1;
	assign right_addr     = col_q + CW'(ch_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= pixel_in.pixel_sample;
			col_s1   <= col_q;
			flags_s1 <= in_flags;
		end
	end

	// Line stores: shift the middle row into the above row as stage 1 leaves
	lsh_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_SAMPLES)) u_row_above (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (centre_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	// Two copies of the middle row serve the centre and right reads
	lsh_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_SAMPLES)) u_row_middle_c (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (x_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (centre_rd)
	);

	lsh_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_SAMPLES)) u_row_middle_r (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (x_s1),
		.re    (accept),
		.raddr (right_addr),
		.rdata (right_rd)
	);

	// Left neighbor: centre bytes of the last four items, pick by channel count
	logic [PIX_W-1:0] ctr_tap_q [4];
	logic [PIX_W-1:0] left_val;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ctr_tap_q[0] <= centre_rd;
			for (int i = 1; i < 4; i++) begin
				ctr_tap_q[i] <= ctr_tap_q[i-1];
			end
		end
	end

	assign left_val = ctr_tap_q[2'(ch_eff - 3'd1)];

	// ------------------------------------------------------------------
	// Laplacian and saturation
	// ------------------------------------------------------------------
	logic signed [12:0] lap_sum;
	logic [PIX_W-1:0]   lap_sat;
	logic [PIX_W-1:0]   result_val;

	always_comb begin
		lap_sum = $signed({2'b00, centre_rd, 2'b00}) + $signed({5'b0, centre_rd})
			- $signed({5'b0, left_val}) - $signed({5'b0, right_rd})
			- $signed({5'b0, up_rd}) - $signed({5'b0, x_s1});
		if (lap_sum < 13'sd0) begin
			lap_sat = '0;
		end else if (lap_sum > 13'sd255) begin
			lap_sat = '1;
		end else begin
			lap_sat = lap_sum[PIX_W-1:0];
		end
		result_val = (flags_s1.row_ge2 && flags_s1.interior) ? lap_sat : '0;
	end

	// ------------------------------------------------------------------
	// Stage 2: output register with one queued border result
	// ------------------------------------------------------------------
	logic             valid_s2;
	logic             pend_s2;
	logic [PIX_W-1:0] sample_s2;
	logic             end_s2;
	logic             pend_end_s2;
	logic             out_take;
	logic             load_s2;

	assign out_take = valid_s2 && sharp_out.ready;
	assign load_ok  = !valid_s2 || (sharp_out.ready && !pend_s2);
	assign load_s2  = adv_s1 && flags_s1.row_ge1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pend_s2  <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			pend_s2  <= flags_s1.last_row;
		end else if (out_take) begin
			// advance the queued border result, else drop the request
			if (pend_s2) begin
				pend_s2 <= 1'b0;
			end else begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			sample_s2   <= result_val;
			end_s2      <= 1'b0;
			pend_end_s2 <= flags_s1.last_sample;
		end else if (out_take && pend_s2) begin
			sample_s2 <= '0;
			end_s2    <= pend_end_s2;
		end
	end

	assign sharp_out.valid        = valid_s2;
	assign sharp_out.sharp_sample = sample_s2;
	assign sharp_out.frame_end    = end_s2;

endmodule

// ===== tb/laplacian_sharpen_3x3_test.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_test
// Self-checking bench for the streaming 3x3 Laplacian sharpener.
// ----------------------------------------------------------------------------
// A driver feeds channel bytes from a backlog queue over the pixel channel.
// A monitor predicts the sharpened results of every accepted request and
// compares them, field by field, with what leaves the result channel. The
// register port reshapes the image between phases: tiny frames with hand-made
// content first, then many small random frames, and the opening stretch of a
// row at the largest width. Both sides idle at random. One phase has a long
// receiver hold-off. Another phase runs with no idling at all.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_test;
	import lsh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_CAPACITY  = 8192;     // line store depth of the instance
	localparam int SHARPEN_GAIN  = 5;        // weight of the centre sample
	localparam int PIX_MAX       = (1 << PIX_W) - 1;
	localparam int IDLE_PCT      = 18;       // idle cycles per hundred, each side
	localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
	localparam int SETTLE_CYCLES = 8;        // margin for the pipeline to clear
	localparam int RANDOM_ITEMS  = 1200;
	localparam int FINAL_ITEMS   = 250;      // bytes sent at the largest width
	localparam int CYCLE_LIMIT   = 600000;

	// Byte address bits [3:2] select a register; this index maps to none.
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] sample;
		logic             last;
	} sharp_result_t;

	typedef enum int {
		STYLE_NOISE,
		STYLE_EXTREME,
		STYLE_SMOOTH
	} pixel_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Register port, driven only by the stimulus process
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	lsh_pixel_if pix_ch ();
	lsh_sharp_if sharp_ch ();

	logic             pix_valid = 1'b0;
	logic [PIX_W-1:0] pix_data = '0;
	logic             sink_ready = 1'b0;

	assign pix_ch.valid        = pix_valid;
	assign pix_ch.pixel_sample = pix_data;
	assign sharp_ch.ready      = sink_ready;

	laplacian_sharpen_3x3 #(
		.MAX_ROW_SAMPLES(ROW_CAPACITY)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pixel_in (pix_ch),
		.sharp_out(sharp_ch)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------------
	logic [PIX_W-1:0] pixel_backlog [$];   // bytes waiting for the driver
	sharp_result_t    pending_sharp [$];   // results owed by the block, oldest first
	int unsigned      pixels_queued = 0;
	int unsigned      pixels_taken = 0;
	int unsigned      mismatch_count = 0;
	int unsigned      cycle_count = 0;
	int unsigned      hold_requests = 0;
	int unsigned      hold_served = 0;
	int unsigned      hold_left = 0;
	bit               steady_flow = 1'b0;  // suppress idling on both sides

	// Predictor copy of the registers and the frame position
	logic [WIDTH_W-1:0]  width_reg = WIDTH_RST;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RST;
	logic [CHAN_W-1:0]   chan_reg = CHAN_RST;
	int unsigned         frame_col = 0;
	int unsigned         frame_row = 0;
	logic [PIX_W-1:0]    upper_line [ROW_CAPACITY];
	logic [PIX_W-1:0]    middle_line [ROW_CAPACITY];

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	// Effective geometry: saturate every register, then cap the width so that
	// one row of interleaved bytes fits in a line store.
	function automatic void frame_geometry(output int unsigned row_len,
			output int unsigned rows, output int unsigned chans);
		int unsigned px;
		chans = (chan_reg < CHAN_MIN) ? CHAN_MIN : (chan_reg > CHAN_MAX) ? CHAN_MAX : chan_reg;
		px = (width_reg < WIDTH_MIN) ? WIDTH_MIN : (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
		if (px > ROW_CAPACITY / chans)
			px = ROW_CAPACITY / chans;
		row_len = px * chans;
		rows = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN :
			(height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg;
	endfunction

	function automatic int unsigned frame_samples();
		int unsigned row_len, rows, chans;
		frame_geometry(row_len, rows, chans);
		return row_len * rows;
	endfunction

	// Advance the frame by one accepted byte and queue the results it owes.
	function automatic void sharpen_predict(input logic [PIX_W-1:0] pix);
		int unsigned   row_len, rows, chans, c;
		logic [PIX_W-1:0] up, centre, right, left;
		int            acc;
		bit            interior, last_row;
		sharp_result_t res;
		frame_geometry(row_len, rows, chans);
		if (frame_col >= row_len)
			frame_col = 0;
		if (frame_row > rows - 1)
			frame_row = 0;
		c = frame_col;

		up = upper_line[c];
		centre = middle_line[c];
		right = (c + chans < row_len) ? middle_line[c + chans] : '0;
		upper_line[c] = centre;
		middle_line[c] = pix;
		// the left neighbor of the middle row has already moved up a line
		left = (c >= chans) ? upper_line[c - chans] : '0;

		interior = (c >= chans) && (c < row_len - chans);
		last_row = (frame_row == rows - 1);

		if (frame_row >= 1) begin
			res.sample = '0;
			res.last = 1'b0;
			if (frame_row >= 2 && interior) begin
				acc = SHARPEN_GAIN * int'(centre) - int'(left) - int'(right)
					- int'(up) - int'(pix);
				if (acc < 0)
					acc = 0;
				else if (acc > PIX_MAX)
					acc = PIX_MAX;
				res.sample = acc[PIX_W-1:0];
			end
			pending_sharp = {pending_sharp, res};
			// the last row also emits its own zero border
			if (last_row) begin
				res.sample = '0;
				res.last = (c == row_len - 1);
				pending_sharp = {pending_sharp, res};
			end
		end

		c++;
		if (c >= row_len) begin
			c = 0;
			frame_row = last_row ? 0 : frame_row + 1;
		end
		frame_col = c;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offer the next byte whenever the current request is gone
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (!pix_valid || pix_ch.ready) begin
			if (pixel_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
				pix_data <= pixel_backlog.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Predict at the edge that accepts a request; count it in the same step so
	// the stimulus process never sees one without the other.
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			sharpen_predict(pix_ch.pixel_sample);
			pixels_taken++;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			sink_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	// Monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		sharp_result_t want;
		if (arst_n && sharp_ch.valid && sharp_ch.ready) begin
			if (pending_sharp.size() == 0) begin
				report_mismatch("unexpected result, sample", sharp_ch.sharp_sample, 0);
			end else begin
				want = pending_sharp.pop_front();
				if (sharp_ch.sharp_sample !== want.sample)
					report_mismatch("sharp_sample", sharp_ch.sharp_sample, want.sample);
				if (sharp_ch.frame_end !== want.last)
					report_mismatch("frame_end", sharp_ch.frame_end, want.last);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Write one register over a setup and an access cycle, then mirror it.
	// Bits above the register width carry random junk that must be dropped.
	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		logic [DATA_W-1:0] data;
		data = $urandom();
		case (idx)
			REG_WIDTH:    data[WIDTH_W-1:0] = value[WIDTH_W-1:0];
			REG_HEIGHT:   data[HEIGHT_W-1:0] = value[HEIGHT_W-1:0];
			REG_CHANNELS: data[CHAN_W-1:0] = value[CHAN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;

		// Any real register restarts the frame; the spare index does nothing.
		case (idx)
			REG_WIDTH:    width_reg = data[WIDTH_W-1:0];
			REG_HEIGHT:   height_reg = data[HEIGHT_W-1:0];
			REG_CHANNELS: chan_reg = data[CHAN_W-1:0];
			default:      return;
		endcase
		frame_col = 0;
		frame_row = 0;
	endtask

	task automatic set_geometry(input int unsigned w, input int unsigned h,
			input int unsigned ch);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_CHANNELS, ch);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(input pixel_style_t style,
			input logic [PIX_W-1:0] base);
		int v;
		case (style)
			STYLE_EXTREME: v = $urandom_range(1) ? PIX_MAX : 0;
			STYLE_SMOOTH: begin
				// small ripple on a flat level keeps results near the level
				v = int'(base) + int'($urandom_range(16)) - 8;
				if (v < 0)
					v = 0;
				else if (v > PIX_MAX)
					v = PIX_MAX;
			end
			default: v = $urandom_range(PIX_MAX);
		endcase
		return v[PIX_W-1:0];
	endfunction

	task automatic queue_pixels(input int unsigned count, input pixel_style_t style);
		logic [PIX_W-1:0] base;
		base = $urandom_range(40, 215);
		repeat (count) begin
			pixel_backlog = {pixel_backlog, pick_pixel(style, base)};
			pixels_queued++;
		end
	endtask

	task automatic queue_literal(input logic [PIX_W-1:0] pix);
		pixel_backlog = {pixel_backlog, pix};
		pixels_queued++;
	endtask

	// Hold until every queued byte is in and every result is out, then give
	// row-zero bytes, which owe nothing, time to clear the pipeline.
	task automatic wait_idle();
		do @(posedge clk); while (pixels_taken != pixels_queued || pending_sharp.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int unsigned  phase;
		int unsigned  total;
		int unsigned  split;
		pixel_style_t style;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest image, set through values below the legal range.
		set_geometry(0, 2, 0);

		// Bright dot on black: the centre saturates high.
		for (int i = 0; i < 9; i++)
			queue_literal((i == 4) ? PIX_W'(PIX_MAX) : '0);
		wait_idle();

		// Dark dot on white, cut in two; the spare register index written in
		// the pause must not restart the frame.
		for (int i = 0; i < 4; i++)
			queue_literal(PIX_W'(PIX_MAX));
		wait_idle();
		write_reg(REG_SPARE, $urandom());
		queue_literal('0);
		for (int i = 0; i < 4; i++)
			queue_literal(PIX_W'(PIX_MAX));
		wait_idle();

		// Half a frame, then restart it by rewriting the width.
		queue_pixels(5, STYLE_NOISE);
		wait_idle();
		write_reg(REG_WIDTH, 3);

		// Random small frames. A few phases carry extra pressure.
		phase = 0;
		while (pixels_queued < RANDOM_ITEMS) begin
			if (phase == 2) begin
				set_geometry(14, 6, 4);
			end else begin
				if ($urandom_range(3) != 0)
					write_reg(REG_WIDTH, ($urandom_range(8) == 0) ?
						$urandom_range(2) : $urandom_range(3, 14));
				if ($urandom_range(3) != 0)
					write_reg(REG_HEIGHT, ($urandom_range(8) == 0) ?
						$urandom_range(2) : $urandom_range(3, 7));
				if ($urandom_range(3) != 0)
					write_reg(REG_CHANNELS, $urandom_range(7));
			end
			style = pixel_style_t'($urandom_range(2));
			total = frame_samples();
			// drop the tail of some frames; the next write restarts anyway
			if (phase != 2 && $urandom_range(4) == 0)
				total = $urandom_range(1, total - 1);

			if (phase == 2) begin
				// Hold the receiver off while the sender keeps offering, so the
				// block fills up and drops its input ready.
				queue_pixels(total, style);
				hold_requests++;
				wait_idle();
			end else if (phase == 6) begin
				// Pause the sender mid-frame until the block has drained.
				split = total / 2;
				queue_pixels(split, style);
				wait_idle();
				write_reg(REG_SPARE, $urandom());
				queue_pixels(total - split, style);
				wait_idle();
			end else if (phase == 4) begin
				// Run a frame (its tail may be dropped) without a single idle cycle on either side.
				steady_flow = 1'b1;
				queue_pixels(total, style);
				wait_idle();
				steady_flow = 1'b0;
			end else begin
				queue_pixels(total, style);
				wait_idle();
			end
			phase++;
		end

		// Upper extremes, saturated from above: the opening stretch of a row
		// at the store depth, which owes no results.
		set_geometry(12'hFFF, 12'hFFF, 7);
		queue_pixels(FINAL_ITEMS, STYLE_NOISE);
		wait_idle();

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lsh_pkg.sv
rtl/lsh_pixel_if.sv
rtl/lsh_sharp_if.sv
rtl/lsh_ram.sv
rtl/laplacian_sharpen_3x3.sv
tb/laplacian_sharpen_3x3_test.sv
